@@ design/cspf_pkg.sv @@
// Package: shared types and constants for the clock set frame parser.
`timescale 1ns / 1ps

package cspf_pkg;

    localparam int FRAME_LEN = 12;
    localparam int POS_CLOSE = 11;
    localparam int POS_SEL   = 1;
    localparam int POS_HOURS = 3;
    localparam int POS_MINS  = 6;
    localparam int POS_SECS  = 9;
    localparam int FILL_W    = 4;

    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;
    localparam logic [7:0] CH_TIME  = 8'h73;
    localparam logic [7:0] CH_ALARM = 8'h61;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    localparam int MAX_HOURS  = 23;
    localparam int MAX_MINSEC = 59;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_IDLE = 1'b1;

    localparam logic [1:0] REPLY_NONE  = 2'd0;
    localparam logic [1:0] REPLY_ERROR = 2'd1;
    localparam logic [1:0] REPLY_OK    = 2'd2;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } cspf_in_t;

    typedef struct packed {
        logic [1:0] reply;
        logic       set_time;
        logic       set_alarm;
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
    } cspf_out_t;

endpackage

@@ design/cspf_pair_decode.sv @@
// Two-digit ASCII pair to value with range check.
`timescale 1ns / 1ps

module cspf_pair_decode #(
    parameter int MAX_VALUE = cspf_pkg::MAX_MINSEC
) (
    input  logic [7:0] tens,
    input  logic [7:0] units,
    output logic [5:0] value,
    output logic       in_range
);
    import cspf_pkg::*;

    logic signed [12:0] tens_s;
    logic signed [12:0] units_s;
    logic signed [12:0] sum_s;

    always_comb begin
        tens_s   = $signed({5'b0, tens}) - 13'sd48;
        units_s  = $signed({5'b0, units}) - 13'sd48;
        sum_s    = (tens_s <<< 3) + (tens_s <<< 1) + units_s;
        in_range = (sum_s >= 13'sd0) && (sum_s <= 13'(MAX_VALUE));
        value    = sum_s[5:0];
    end

endmodule

@@ design/cspf_frame_core.sv @@
// Frame store, fill position and per-event result logic.
`timescale 1ns / 1ps

module cspf_frame_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step_en,
    input  cspf_pkg::cspf_in_t  item,
    output cspf_pkg::cspf_out_t result
);
    import cspf_pkg::*;

    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [7:0]        frame_reg [1:POS_CLOSE];
    logic              store_en;
    logic              close_fix;

    logic [5:0] hours_val;
    logic [5:0] mins_val;
    logic [5:0] secs_val;
    logic       hours_ok;
    logic       mins_ok;
    logic       secs_ok;
    logic       sel_time;
    logic       sel_alarm;

    cspf_pair_decode #(.MAX_VALUE(MAX_HOURS)) u_hours (
        .tens     (frame_reg[POS_HOURS]),
        .units    (frame_reg[POS_HOURS+1]),
        .value    (hours_val),
        .in_range (hours_ok)
    );

    cspf_pair_decode #(.MAX_VALUE(MAX_MINSEC)) u_mins (
        .tens     (frame_reg[POS_MINS]),
        .units    (frame_reg[POS_MINS+1]),
        .value    (mins_val),
        .in_range (mins_ok)
    );

    cspf_pair_decode #(.MAX_VALUE(MAX_MINSEC)) u_secs (
        .tens     (frame_reg[POS_SECS]),
        .units    (frame_reg[POS_SECS+1]),
        .value    (secs_val),
        .in_range (secs_ok)
    );

    assign sel_time  = (frame_reg[POS_SEL] == CH_TIME);
    assign sel_alarm = (frame_reg[POS_SEL] == CH_ALARM);

    always_comb begin
        fill_next = fill_reg;
        store_en  = 1'b0;
        close_fix = 1'b0;
        result    = '0;
        result.reply = REPLY_NONE;
        if (item.kind == KIND_BYTE) begin
            if (fill_reg != '0) begin
                store_en = 1'b1;
                if (fill_reg == FILL_W'(FRAME_LEN)) begin
                    fill_next    = '0;
                    result.reply = REPLY_ERROR;
                end else begin
                    fill_next = fill_reg + FILL_W'(1);
                end
            end else if (item.rx_byte == CH_OPEN) begin
                fill_next = FILL_W'(1);
            end
        end else begin
            fill_next = '0;
            if (frame_reg[POS_CLOSE] != CH_CLOSE) begin
                result.reply = REPLY_ERROR;
            end else begin
                close_fix = 1'b1;
                if (!(sel_time || sel_alarm) || !(hours_ok && mins_ok && secs_ok)) begin
                    result.reply = REPLY_ERROR;
                end else begin
                    result.reply     = REPLY_OK;
                    result.set_time  = sel_time;
                    result.set_alarm = sel_alarm;
                    result.hours     = hours_val[4:0];
                    result.minutes   = mins_val;
                    result.seconds   = secs_val;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            for (int i = 1; i <= POS_CLOSE; i++) begin
                frame_reg[i] <= '0;
            end
        end else if (step_en) begin
            fill_reg <= fill_next;
            for (int i = 1; i <= POS_CLOSE; i++) begin
                if (store_en && fill_reg == FILL_W'(i)) begin
                    frame_reg[i] <= item.rx_byte;
                end
            end
            if (close_fix) begin
                frame_reg[POS_CLOSE] <= CH_ZERO;
            end
        end
    end

endmodule

@@ design/clock_set_frame_parser.sv @@
// Top level: input register, frame core and result register.
// An input goes through the input register, then the result register, to m_.
// Throughput: one input transfer per cycle unless m_ready stalls; one result per input event.
// Rate set by the single pass from the input register through the frame core.
// Reset (aresetn low, synchronous): both stages empty, no frame open, store zeroed.
`timescale 1ns / 1ps

module clock_set_frame_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  cspf_pkg::cspf_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output cspf_pkg::cspf_out_t m_data
);
    import cspf_pkg::*;

    logic      in_valid_reg;
    cspf_in_t  in_data_reg;
    logic      out_valid_reg;
    cspf_out_t out_data_reg;
    cspf_out_t core_result;
    logic      advance;
    logic      step_en;

    assign advance = !out_valid_reg || m_ready;
    assign step_en = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    cspf_frame_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .item    (in_data_reg),
        .result  (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (step_en) begin
            out_data_reg <= core_result;
        end
    end

endmodule
